// File: design/t2t_pkg.sv
// Shared types, constants and helpers for the Type 2 tag NDEF TLV extractor.
// No dependencies; used by every module in the design folder.
package t2t_pkg;

    // Input beat: one tag memory byte
    typedef struct packed {
        logic       func;
        logic [7:0] tag_byte;
        logic       read_failed;
    } t2t_in_t;

    // Output beat: one message byte or a failure report
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       is_byte;
        logic       is_last;
        logic       failed;
        logic [2:0] fail_reason;
    } t2t_res_t;

    // Up to two results produced by one accepted input beat
    typedef struct packed {
        logic [1:0] count;
        t2t_res_t   r0;
        t2t_res_t   r1;
    } t2t_step_t;

    // Byte codes
    localparam logic [7:0] CC_MAGIC    = 8'hE1;
    localparam logic [7:0] TLV_PAD     = 8'h00;
    localparam logic [7:0] TLV_TERM    = 8'hFE;
    localparam logic [7:0] TLV_NDEF    = 8'h03;
    localparam logic [7:0] LEN_ESCAPE  = 8'hFF;

    // Failure reasons
    localparam logic [2:0] FAIL_CC_MAGIC  = 3'd0;
    localparam logic [2:0] FAIL_TERM      = 3'd1;
    localparam logic [2:0] FAIL_TLV_TYPE  = 3'd2;
    localparam logic [2:0] FAIL_LENGTH    = 3'd3;
    localparam logic [2:0] FAIL_OVERRUN   = 3'd4;
    localparam logic [2:0] FAIL_READ      = 3'd5;

    localparam logic [15:0] MAX_MSG_RESET = 16'd1024;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    function automatic t2t_res_t make_fail(input logic [2:0] reason);
        t2t_res_t r;
        r             = '0;
        r.failed      = 1'b1;
        r.fail_reason = reason;
        return r;
    endfunction

    function automatic t2t_res_t make_byte(input logic [7:0] b, input logic last);
        t2t_res_t r;
        r          = '0;
        r.msg_byte = b;
        r.is_byte  = 1'b1;
        r.is_last  = last;
        return r;
    endfunction

endpackage

// File: design/t2t_parser.sv
// Per-byte parser: walk state registers plus the single-pass next-state logic.
// Depends on t2t_pkg.
module t2t_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               accept,
    input  t2t_pkg::t2t_in_t   in_beat,
    output t2t_pkg::t2t_step_t step
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CC_OK  = 3'd1;
    localparam logic [2:0] PH_CC_BAD = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_LEN0   = 3'd4;
    localparam logic [2:0] PH_LENHI  = 3'd5;
    localparam logic [2:0] PH_LENLO  = 3'd6;
    localparam logic [2:0] PH_BODY   = 3'd7;

    logic [15:0] max_msg_reg;
    logic [2:0]  phase_reg,   phase_next;
    logic [16:0] area_reg,    area_next;
    logic [7:0]  len_hi_reg,  len_hi_next;
    logic [15:0] msg_len_reg, msg_len_next;
    logic [15:0] body_cnt_reg, body_cnt_next;

    logic [15:0] len_val;
    logic [16:0] len_plus2;
    logic [15:0] body_inc;
    logic        len_ok;

    // Length candidate for the length-complete check
    always_comb begin
        if (phase_reg == PH_LENLO) begin
            len_val = {len_hi_reg, in_beat.tag_byte};
        end else begin
            len_val = {8'd0, in_beat.tag_byte};
        end
        len_plus2 = {1'b0, len_val} + 17'd2;
        len_ok    = (len_val != 16'd0) && (len_plus2 <= {1'b0, max_msg_reg});
        body_inc  = body_cnt_reg + 16'd1;
    end

    // Next state and results for the beat being accepted
    always_comb begin
        phase_next    = phase_reg;
        area_next     = area_reg;
        len_hi_next   = len_hi_reg;
        msg_len_next  = msg_len_reg;
        body_cnt_next = body_cnt_reg;
        step          = '0;

        if (accept) begin
            if (in_beat.func) begin
                // new tag: first CC byte
                if (in_beat.read_failed) begin
                    phase_next = PH_IDLE;
                    step.count = 2'd1;
                    step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_READ);
                end else begin
                    phase_next = (in_beat.tag_byte == t2t_pkg::CC_MAGIC) ? PH_CC_OK
                                                                         : PH_CC_BAD;
                    area_next  = 17'd1;
                end
            end else if (phase_reg == PH_IDLE) begin
                // bytes ignored until the next tag
            end else if (phase_reg == PH_TYPE &&
                         area_reg > {1'b0, max_msg_reg}) begin
                phase_next = PH_IDLE;
                step.count = 2'd1;
                step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_OVERRUN);
            end else if (in_beat.read_failed) begin
                phase_next = PH_IDLE;
                step.count = 2'd1;
                step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_READ);
            end else begin
                unique case (phase_reg)
                    PH_CC_OK, PH_CC_BAD: begin
                        if (area_reg >= 17'd3) begin
                            if (phase_reg == PH_CC_BAD) begin
                                phase_next = PH_IDLE;
                                step.count = 2'd1;
                                step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_CC_MAGIC);
                            end else begin
                                phase_next = PH_TYPE;
                                area_next  = 17'd0;
                            end
                        end else begin
                            area_next = area_reg + 17'd1;
                        end
                    end
                    PH_TYPE: begin
                        if (in_beat.tag_byte == t2t_pkg::TLV_PAD) begin
                            area_next = area_reg + 17'd1;
                        end else if (in_beat.tag_byte == t2t_pkg::TLV_TERM) begin
                            phase_next = PH_IDLE;
                            step.count = 2'd1;
                            step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_TERM);
                        end else if (in_beat.tag_byte != t2t_pkg::TLV_NDEF) begin
                            phase_next = PH_IDLE;
                            step.count = 2'd1;
                            step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_TLV_TYPE);
                        end else begin
                            phase_next = PH_LEN0;
                        end
                    end
                    PH_LENHI: begin
                        len_hi_next = in_beat.tag_byte;
                        phase_next  = PH_LENLO;
                    end
                    PH_LEN0, PH_LENLO: begin
                        if (phase_reg == PH_LEN0 &&
                            in_beat.tag_byte == t2t_pkg::LEN_ESCAPE) begin
                            phase_next = PH_LENHI;
                        end else if (!len_ok) begin
                            phase_next = PH_IDLE;
                            step.count = 2'd1;
                            step.r0    = t2t_pkg::make_fail(t2t_pkg::FAIL_LENGTH);
                        end else begin
                            // length known: emit big-endian prefix
                            phase_next    = PH_BODY;
                            msg_len_next  = len_val;
                            body_cnt_next = 16'd0;
                            step.count    = 2'd2;
                            step.r0       = t2t_pkg::make_byte(len_val[15:8], 1'b0);
                            step.r1       = t2t_pkg::make_byte(len_val[7:0], 1'b0);
                        end
                    end
                    PH_BODY: begin
                        body_cnt_next = body_inc;
                        step.count    = 2'd1;
                        if (body_inc >= msg_len_reg) begin
                            phase_next = PH_IDLE;
                            step.r0    = t2t_pkg::make_byte(in_beat.tag_byte, 1'b1);
                        end else begin
                            step.r0    = t2t_pkg::make_byte(in_beat.tag_byte, 1'b0);
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // State and limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_msg_reg  <= t2t_pkg::MAX_MSG_RESET;
            phase_reg    <= PH_IDLE;
            area_reg     <= '0;
            len_hi_reg   <= '0;
            msg_len_reg  <= '0;
            body_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                max_msg_reg <= cfg_wdata;
            end
            phase_reg    <= phase_next;
            area_reg     <= area_next;
            len_hi_reg   <= len_hi_next;
            msg_len_reg  <= msg_len_next;
            body_cnt_reg <= body_cnt_next;
        end
    end

endmodule

// File: design/t2t_rsq.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on t2t_pkg.
module t2t_rsq (
    input  logic               aclk,
    input  logic               aresetn,
    input  t2t_pkg::t2t_step_t step,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output t2t_pkg::t2t_res_t  m_data
);

    t2t_pkg::t2t_res_t          q_mem [t2t_pkg::RQ_DEPTH];
    logic [t2t_pkg::RQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [t2t_pkg::RQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [t2t_pkg::RQ_AW:0]    cnt_reg,    cnt_next;
    logic [t2t_pkg::RQ_AW-1:0]  wr_ptr_p1;
    logic                       pop;

    // Space for a full two-result step keeps the input side independent of m_ready
    assign room    = cnt_reg <= (t2t_pkg::RQ_AW+1)'(t2t_pkg::RQ_DEPTH - 2);
    assign m_valid = cnt_reg != '0;
    assign m_data  = q_mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_p1   = wr_ptr_reg + {{(t2t_pkg::RQ_AW-1){1'b0}}, 1'b1};
        wr_ptr_next = wr_ptr_reg + step.count[t2t_pkg::RQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(t2t_pkg::RQ_AW-1){1'b0}}, pop};
        cnt_next    = cnt_reg + {{(t2t_pkg::RQ_AW-1){1'b0}}, step.count}
                              - {{t2t_pkg::RQ_AW{1'b0}}, pop};
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (step.count != 2'd0) begin
            q_mem[wr_ptr_reg] <= step.r0;
        end
        if (step.count == 2'd2) begin
            q_mem[wr_ptr_p1] <= step.r1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: design/type2_tag_ndef_tlv_extractor_unit.sv
// Top level of the Type 2 tag NDEF TLV extractor.
// Depends on t2t_pkg, t2t_parser and t2t_rsq.
//
//  channel | ports                     | beat
//  --------+---------------------------+----------------------------------------
//  input   | s_valid s_ready s_data    | one tag byte (func, tag_byte, read_failed)
//  output  | m_valid m_ready m_data    | one message byte or failure report
//  config  | cfg_we cfg_wdata          | max_message_bytes, no wait, no read-back
//
// One input beat per cycle while s_ready is high; each beat is parsed in the cycle it is accepted
// and its zero, one or two results are written into a four-entry result queue.
// A result is available on m_data at the earliest the cycle after its input beat,
// behind any results still queued.
// s_ready drops only while the queue holds more than two results (output stall).
// Synchronous active-low reset: parser idle, limit 1024, queue empty.
module type2_tag_ndef_tlv_extractor_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  t2t_pkg::t2t_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output t2t_pkg::t2t_res_t  m_data
);

    t2t_pkg::t2t_step_t step;
    logic               accept;

    assign accept = s_valid && s_ready;

    t2t_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_beat   (s_data),
        .step      (step)
    );

    t2t_rsq u_rsq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/t2t_extract_checker.sv
// Scoreboard for the Type 2 tag NDEF TLV extractor: tracks the TLV walk per beat,
// predicts message bytes and failure reports, compares them against the result channel.
// Depends on t2t_pkg for the beat structs and the byte and failure codes.
`timescale 1ns / 100ps

module t2t_extract_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  t2t_pkg::t2t_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  t2t_pkg::t2t_res_t m_data,
    output int unsigned       pending,
    output int unsigned       err_count,
    output int unsigned       beats_in,
    output int unsigned       beats_out,
    output int unsigned       msgs_done,
    output int unsigned       aborts
);

    localparam logic [2:0] W_IDLE   = 3'd0;
    localparam logic [2:0] W_CC_OK  = 3'd1;
    localparam logic [2:0] W_CC_BAD = 3'd2;
    localparam logic [2:0] W_TYPE   = 3'd3;
    localparam logic [2:0] W_LEN0   = 3'd4;
    localparam logic [2:0] W_LEN_HI = 3'd5;
    localparam logic [2:0] W_LEN_LO = 3'd6;
    localparam logic [2:0] W_BODY   = 3'd7;

    // Walker state and the staged-size limit
    logic [2:0]  phase;
    logic [16:0] area_ofs;
    logic [7:0]  len_hi;
    logic [15:0] msg_len;
    logic [15:0] body_cnt;
    logic [15:0] limit;

    t2t_pkg::t2t_res_t expected_bytes [$];

    function automatic void push_fail(input logic [2:0] reason);
        t2t_pkg::t2t_res_t r;
        r             = '0;
        r.failed      = 1'b1;
        r.fail_reason = reason;
        expected_bytes.push_back(r);
        phase = W_IDLE;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last);
        t2t_pkg::t2t_res_t r;
        r          = '0;
        r.msg_byte = b;
        r.is_byte  = 1'b1;
        r.is_last  = last;
        expected_bytes.push_back(r);
    endfunction

    // Length complete: range check, then the big-endian prefix goes out in one step
    function automatic void length_done(input logic [15:0] len);
        if (len == 16'd0 || ({1'b0, len} + 17'd2) > {1'b0, limit}) begin
            push_fail(t2t_pkg::FAIL_LENGTH);
        end else begin
            msg_len  = len;
            body_cnt = 16'd0;
            phase    = W_BODY;
            push_byte(len[15:8], 1'b0);
            push_byte(len[7:0], 1'b0);
        end
    endfunction

    function automatic void predict_walk(input t2t_pkg::t2t_in_t d);
        // first CC byte restarts the walk from any phase
        if (d.func) begin
            if (d.read_failed) begin
                push_fail(t2t_pkg::FAIL_READ);
            end else begin
                phase    = (d.tag_byte == t2t_pkg::CC_MAGIC) ? W_CC_OK : W_CC_BAD;
                area_ofs = 17'd1;
            end
            return;
        end
        case (phase)
            W_CC_OK, W_CC_BAD: begin
                if (d.read_failed) begin
                    push_fail(t2t_pkg::FAIL_READ);
                end else begin
                    area_ofs = area_ofs + 17'd1;
                    if (area_ofs >= 17'd4) begin
                        if (phase == W_CC_BAD) begin
                            push_fail(t2t_pkg::FAIL_CC_MAGIC);
                        end else begin
                            phase    = W_TYPE;
                            area_ofs = 17'd0;
                        end
                    end
                end
            end
            // overrun is judged ahead of a read error on the type byte
            W_TYPE: begin
                if (area_ofs > {1'b0, limit}) begin
                    push_fail(t2t_pkg::FAIL_OVERRUN);
                end else if (d.read_failed) begin
                    push_fail(t2t_pkg::FAIL_READ);
                end else if (d.tag_byte == t2t_pkg::TLV_PAD) begin
                    area_ofs = area_ofs + 17'd1;
                end else if (d.tag_byte == t2t_pkg::TLV_TERM) begin
                    push_fail(t2t_pkg::FAIL_TERM);
                end else if (d.tag_byte != t2t_pkg::TLV_NDEF) begin
                    push_fail(t2t_pkg::FAIL_TLV_TYPE);
                end else begin
                    phase = W_LEN0;
                end
            end
            W_LEN0: begin
                if (d.read_failed) begin
                    push_fail(t2t_pkg::FAIL_READ);
                end else if (d.tag_byte == t2t_pkg::LEN_ESCAPE) begin
                    phase = W_LEN_HI;
                end else begin
                    length_done({8'h00, d.tag_byte});
                end
            end
            W_LEN_HI: begin
                if (d.read_failed) begin
                    push_fail(t2t_pkg::FAIL_READ);
                end else begin
                    len_hi = d.tag_byte;
                    phase  = W_LEN_LO;
                end
            end
            W_LEN_LO: begin
                if (d.read_failed) begin
                    push_fail(t2t_pkg::FAIL_READ);
                end else begin
                    length_done({len_hi, d.tag_byte});
                end
            end
            W_BODY: begin
                if (d.read_failed) begin
                    push_fail(t2t_pkg::FAIL_READ);
                end else begin
                    body_cnt = body_cnt + 16'd1;
                    push_byte(d.tag_byte, body_cnt >= msg_len);
                    if (body_cnt >= msg_len) begin
                        phase = W_IDLE;
                    end
                end
            end
            default: phase = W_IDLE;
        endcase
    endfunction

    function automatic string show(input t2t_pkg::t2t_res_t r);
        return $sformatf("byte=%02h is_byte=%0b last=%0b failed=%0b reason=%0d",
                         r.msg_byte, r.is_byte, r.is_last, r.failed, r.fail_reason);
    endfunction

    // Sampled at the rising edge: inputs and outputs still hold their pre-edge values
    always @(posedge aclk) begin
        t2t_pkg::t2t_res_t want;
        if (!aresetn) begin
            phase     = W_IDLE;
            area_ofs  = '0;
            len_hi    = '0;
            msg_len   = '0;
            body_cnt  = '0;
            limit     = t2t_pkg::MAX_MSG_RESET;
            expected_bytes.delete();
            err_count = 0;
            beats_in  = 0;
            beats_out = 0;
            msgs_done = 0;
            aborts    = 0;
        end else begin
            // result beat against the oldest expectation
            if (m_valid && m_ready) begin
                beats_out++;
                if (m_data.is_last) msgs_done++;
                if (m_data.failed) aborts++;
                if (expected_bytes.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, show(m_data));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data.msg_byte !== want.msg_byte || m_data.is_byte !== want.is_byte ||
                        m_data.is_last !== want.is_last || m_data.failed !== want.failed ||
                        m_data.fail_reason !== want.fail_reason) begin
                        err_count++;
                        $display("%0t: result mismatch, expected %s, got %s",
                                 $time, show(want), show(m_data));
                    end
                end
            end
            // tag byte beat, judged with the limit in force before this edge
            if (s_valid && s_ready) begin
                beats_in++;
                predict_walk(s_data);
            end
            if (cfg_we) limit = cfg_wdata;
        end
        pending = expected_bytes.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for type2_tag_ndef_tlv_extractor_unit: clock, reset, tag byte stimulus,
// result back-pressure, limit register writes and the verdict.
// Needs t2t_pkg and t2t_extract_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int NO_ERR = -1;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [15:0]       cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    t2t_pkg::t2t_in_t  s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    t2t_pkg::t2t_res_t m_data;

    int unsigned pending, err_count, beats_in, beats_out, msgs_done, aborts;

    bit gaps_on      = 1'b1;
    bit sink_gaps_on = 1'b1;
    int sink_hold    = 0;
    int cur_limit    = t2t_pkg::MAX_MSG_RESET;
    int beats_sent   = 0;
    int walk_pos, walk_err;
    int phase_limits [7];

    type2_tag_ndef_tlv_extractor_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    t2t_extract_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .pending   (pending),
        .err_count (err_count),
        .beats_in  (beats_in),
        .beats_out (beats_out),
        .msgs_done (msgs_done),
        .aborts    (aborts)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side back-pressure, switching now and then between stalling and always ready
    always @(posedge aclk) begin : ready_pacing
        int g;
        if ($urandom_range(0, 63) == 0) sink_gaps_on <= !sink_gaps_on;
        g = sink_gaps_on ? pick_gap() : 0;
        if (sink_hold > 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (g == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready   <= 1'b0;
            sink_hold <= g - 1;
        end
    end

    // One tag byte beat; valid holds until the handshake edge
    task automatic send(input logic func, input logic [7:0] b, input logic rf);
        int gap;
        t2t_pkg::t2t_in_t beat;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        beat.func        = func;
        beat.tag_byte    = b;
        beat.read_failed = rf;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic walk_beat(input logic func, input logic [7:0] b);
        send(func, b, walk_pos == walk_err);
        walk_pos++;
    endtask

    // Whole tag: CC bytes, padding, TLV type, length, body; err_at marks a failed read
    task automatic walk_tag(input logic [7:0] magic, input int pads, input logic [7:0] tlv_type,
                            input bit long_form, input int len, input int nbody,
                            input int err_at);
        walk_pos = 0;
        walk_err = err_at;
        walk_beat(1'b1, magic);
        repeat (3) walk_beat(1'b0, 8'($urandom_range(0, 255)));
        repeat (pads) walk_beat(1'b0, t2t_pkg::TLV_PAD);
        walk_beat(1'b0, tlv_type);
        if (long_form) begin
            walk_beat(1'b0, t2t_pkg::LEN_ESCAPE);
            walk_beat(1'b0, len[15:8]);
        end
        walk_beat(1'b0, len[7:0]);
        repeat (nbody) walk_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0) return t2t_pkg::TLV_PAD;
        if (r == 1) return t2t_pkg::TLV_NDEF;
        if (r == 2) return t2t_pkg::TLV_TERM;
        if (r == 3) return t2t_pkg::LEN_ESCAPE;
        if (r == 4) return t2t_pkg::CC_MAGIC;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed tags with random content, some broken ones, some loose noise
    task automatic random_tag();
        int kind, flaw, pads, len, maxlen, nbody, err_at;
        logic [7:0] magic, tlv_type;
        bit long_form;
        kind    = $urandom_range(0, 99);
        gaps_on = ($urandom_range(0, 4) != 0);
        if (kind >= 85) begin
            repeat ($urandom_range(1, 8))
                send($urandom_range(0, 7) == 0, noise_byte(), $urandom_range(0, 7) == 0);
            return;
        end
        maxlen   = (cur_limit >= 3) ? cur_limit - 2 : 1;
        pads     = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 2);
        len      = ($urandom_range(0, 9) == 0) ? maxlen
                                               : $urandom_range(1, (maxlen < 12) ? maxlen : 12);
        magic    = t2t_pkg::CC_MAGIC;
        tlv_type = t2t_pkg::TLV_NDEF;
        err_at   = NO_ERR;
        if (kind >= 70) begin
            flaw = $urandom_range(0, 99);
            if (flaw < 30) begin
                err_at = $urandom_range(0, 4 + pads + 3 + ((len < 16) ? len : 16));
            end else if (flaw < 45) begin
                do magic = 8'($urandom_range(0, 255)); while (magic == t2t_pkg::CC_MAGIC);
            end else if (flaw < 60) begin
                tlv_type = t2t_pkg::TLV_TERM;
            end else if (flaw < 75) begin
                do tlv_type = 8'($urandom_range(0, 255));
                while (tlv_type == t2t_pkg::TLV_PAD || tlv_type == t2t_pkg::TLV_NDEF ||
                       tlv_type == t2t_pkg::TLV_TERM);
            end else if (flaw < 88) begin
                len = 0;
            end else begin
                len = maxlen + $urandom_range(1, 4);
                if (len > 65535) len = 65535;
            end
        end
        long_form = (len > 254) || ($urandom_range(0, 3) == 0);
        nbody     = (len < 16) ? len : $urandom_range(0, 16);
        walk_tag(magic, pads, tlv_type, long_form, len, nbody, err_at);
        // trailing bytes land on an idle walker or run into a cut-short body
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
    endtask

    // Length and overrun boundaries for the current limit
    task automatic limit_edges();
        int lim;
        lim = cur_limit;
        if (lim >= 3)
            walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b1, lim - 2,
                     (lim < 8) ? lim - 2 : 6, NO_ERR);
        if (lim >= 1)
            walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b1, lim - 1, 0, NO_ERR);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b1, 65535, 0, NO_ERR);
        if (lim <= 40) begin
            walk_tag(t2t_pkg::CC_MAGIC, lim, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, NO_ERR);
            walk_tag(t2t_pkg::CC_MAGIC, lim + 1, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, NO_ERR);
            // overrun is reported even when the type byte read fails
            walk_tag(t2t_pkg::CC_MAGIC, lim + 1, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, 4 + lim + 1);
        end
    endtask

    task automatic random_phase(input int n);
        int target;
        target = beats_sent + n;
        while (beats_sent < target) random_tag();
    endtask

    // Park the walker (failed read on a fresh CC byte), then wait for the results to drain
    task automatic drain();
        send(1'b1, 8'h00, 1'b1);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[15:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_limit = value;
    endtask

    initial begin
        phase_limits = '{t2t_pkg::MAX_MSG_RESET, 3, 65535, 1, $urandom_range(4, 40),
                         $urandom_range(3, 65535), t2t_pkg::MAX_MSG_RESET};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle bytes, each failure reason but overrun, both length forms
        send(1'b0, 8'hA5, 1'b0);
        send(1'b0, 8'h5A, 1'b1);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, NO_ERR);
        send(1'b0, 8'hFF, 1'b0);
        walk_tag(t2t_pkg::CC_MAGIC, 1, t2t_pkg::TLV_NDEF, 1'b1, 5, 5, NO_ERR);
        walk_tag(8'hE0, 0, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, NO_ERR);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, 0);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 1, 1, 2);
        walk_tag(t2t_pkg::CC_MAGIC, 2, t2t_pkg::TLV_TERM, 1'b0, 1, 1, NO_ERR);
        walk_tag(t2t_pkg::CC_MAGIC, 0, 8'h01, 1'b0, 1, 1, NO_ERR);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 0, 0, NO_ERR);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b1, 0, 0, NO_ERR);
        // longest short-form length, cut short by the next CC byte
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 254, 3, NO_ERR);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 3, 3, 4);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b1, 3, 3, 7);
        walk_tag(t2t_pkg::CC_MAGIC, 0, t2t_pkg::TLV_NDEF, 1'b0, 3, 3, 7);

        // one limit setting per pass; the first runs on the reset value
        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) set_limit(phase_limits[ph]);
            gaps_on = 1'b1;
            limit_edges();
            random_phase((ph == 3) ? 4 : 10);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Covered %0d tag byte beats and %0d result beats: %0d messages, %0d aborts",
                 beats_in, beats_out, msgs_done, aborts);
        $display("Limits exercised: %0d %0d %0d %0d %0d %0d %0d", phase_limits[0],
                 phase_limits[1], phase_limits[2], phase_limits[3], phase_limits[4],
                 phase_limits[5], phase_limits[6]);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/t2t_pkg.sv
design/t2t_parser.sv
design/t2t_rsq.sv
design/type2_tag_ndef_tlv_extractor_unit.sv
tb/t2t_extract_checker.sv
tb/tb_top.sv
